// ===== rtl/ptt_pkg.sv =====
// shared types, codes and the helper function of the port trigger table
`timescale 1ns / 1ps
package ptt_pkg;

  localparam logic [1:0] CMD_LOOKUP  = 2'd0;
  localparam logic [1:0] CMD_FORWARD = 2'd1;
  localparam logic [1:0] CMD_TRIGGER = 2'd2;
  localparam logic [1:0] CMD_TICK    = 2'd3;

  localparam logic [1:0] VERDICT_CONTINUE = 2'd0;
  localparam logic [1:0] VERDICT_ACCEPT   = 2'd1;
  localparam logic [1:0] VERDICT_REDIRECT = 2'd2;

  localparam logic [7:0]  PROTO_TCP     = 8'd6;
  localparam logic [7:0]  PROTO_UDP     = 8'd17;
  localparam logic [15:0] PORT_END_MARK = 16'hFFFF;

  localparam logic [2:0] REG_TRIG_PROTO = 3'd0;
  localparam logic [2:0] REG_FWD_PROTO  = 3'd1;
  localparam logic [2:0] REG_TRIG_PORTS = 3'd2;
  localparam logic [2:0] REG_TRIG_FLAGS = 3'd3;
  localparam logic [2:0] REG_FWD_PORTS  = 3'd4;
  localparam logic [2:0] REG_FWD_FLAGS  = 3'd5;
  localparam logic [2:0] REG_REFRESH    = 3'd6;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_DRAIN,
    S_DECIDE
  } state_e;

  typedef struct packed {
    logic [7:0]  trig_proto;
    logic [7:0]  fwd_proto;
    logic [63:0] trig_ports;
    logic [3:0]  trig_flags;
    logic [63:0] fwd_ports;
    logic [3:0]  fwd_flags;
    logic [15:0] refresh;
  } cfg_t;

  typedef struct packed {
    logic [31:0] lan;
    logic [7:0]  proto;
    logic [15:0] secs;
  } entry_t;

  typedef struct packed {
    logic load;
    logic rd_en;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic rd_last;
    logic out_busy;
  } ctrl_sts_t;

  // walks the slot list, a ranged slot pairs with the next one
  function automatic logic port_in_list(logic [63:0] list, logic [3:0] flags,
                                        logic [15:0] port, int unsigned nslots);
    logic        done;
    logic        skip;
    logic        hit;
    logic [15:0] lo;
    logic [15:0] hi;
    done = 1'b0;
    skip = 1'b0;
    hit  = 1'b0;
    for (int k = 0; k < 4; k++) begin
      lo = list[16*k +: 16];
      hi = lo;
      if (k < nslots && !done && !skip) begin
        if (flags[k] && lo == PORT_END_MARK) begin
          done = 1'b1;
        end else begin
          if (flags[k] && (k + 1) < nslots) begin
            hi   = list[16*((k + 1) % 4) +: 16];
            skip = 1'b1;
          end
          if (port >= lo && port <= hi) hit = 1'b1;
        end
      end else if (skip) begin
        skip = 1'b0;
      end
    end
    return hit;
  endfunction

endpackage

// ===== rtl/ptt_regs.sv =====
// configuration register file behind the apb port
`timescale 1ns / 1ps
module ptt_regs import ptt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[5:3];
  assign wr_en  = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trig_proto <= '0;
      cfg_q.fwd_proto  <= '0;
      cfg_q.trig_ports <= 64'd65535;
      cfg_q.trig_flags <= 4'd1;
      cfg_q.fwd_ports  <= 64'd65535;
      cfg_q.fwd_flags  <= 4'd1;
      cfg_q.refresh    <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_TRIG_PROTO: cfg_q.trig_proto <= pwdata[7:0];
        REG_FWD_PROTO:  cfg_q.fwd_proto  <= pwdata[7:0];
        REG_TRIG_PORTS: cfg_q.trig_ports <= pwdata;
        REG_TRIG_FLAGS: cfg_q.trig_flags <= pwdata[3:0];
        REG_FWD_PORTS:  cfg_q.fwd_ports  <= pwdata;
        REG_FWD_FLAGS:  cfg_q.fwd_flags  <= pwdata[3:0];
        REG_REFRESH:    cfg_q.refresh    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_TRIG_PROTO: prdata = {56'd0, cfg_q.trig_proto};
      REG_FWD_PROTO:  prdata = {56'd0, cfg_q.fwd_proto};
      REG_TRIG_PORTS: prdata = cfg_q.trig_ports;
      REG_TRIG_FLAGS: prdata = {60'd0, cfg_q.trig_flags};
      REG_FWD_PORTS:  prdata = cfg_q.fwd_ports;
      REG_FWD_FLAGS:  prdata = {60'd0, cfg_q.fwd_flags};
      REG_REFRESH:    prdata = {48'd0, cfg_q.refresh};
      default:        prdata = '0;
    endcase
  end

endmodule

// ===== rtl/ptt_ctrl.sv =====
// controller: accept, table sweep, drain and decision sequencing
`timescale 1ns / 1ps
module ptt_ctrl import ptt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  ctrl_sts_t sts_i,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_SWEEP;
      S_SWEEP:  if (sts_i.rd_last) state_d = S_DRAIN;
      S_DRAIN:  state_d = S_DECIDE;
      S_DECIDE: if (!sts_i.out_busy) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      S_SWEEP:  cmd_o.rd_en = 1'b1;
      S_DRAIN:  ;
      S_DECIDE: cmd_o.commit = !sts_i.out_busy;
      default:  ;
    endcase
  end

  a_commit_after_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> $past(state_q) == S_DRAIN || $past(state_q) == S_DECIDE)
    else $error("commit without a finished sweep");
  a_load_starts_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == S_SWEEP)
    else $error("accepted item did not start a sweep");
  a_sweep_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.rd_en && sts_i.rd_last) |=> state_q == S_DRAIN)
    else $error("sweep ran past the last entry");

endmodule

// ===== rtl/ptt_datapath.sv =====
// datapath: entry memory, valid and rank cells, sweep trackers, result register
`timescale 1ns / 1ps
module ptt_datapath import ptt_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES           = 16,
  parameter int unsigned PORT_SLOTS              = 4,
  parameter int unsigned DEFAULT_TIMEOUT_SECONDS = 600
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  ctrl_cmd_t   cmd_i,
  output ctrl_sts_t   sts_o,
  input  logic [1:0]  command_i,
  input  logic [7:0]  protocol_i,
  input  logic [31:0] src_addr_i,
  input  logic [31:0] dst_addr_i,
  input  logic [15:0] dst_port_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  verdict_o,
  output logic [31:0] nat_addr_o,
  output logic        table_full_o
);

  localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [15:0] DEF_TIMEOUT = 16'(DEFAULT_TIMEOUT_SECONDS);

  // item registers
  logic [1:0]  cmd_q;
  logic [7:0]  proto_q;
  logic [31:0] src_q;
  logic [31:0] dst_q;
  logic [15:0] port_q;

  entry_t mem_q [TABLE_ENTRIES];
  entry_t rd_data_q;
  logic   wr_en;
  logic [IW-1:0] wr_addr;
  entry_t wr_data;

  logic [TABLE_ENTRIES-1:0] valid_q, valid_d;
  logic [IW-1:0] rank_q [TABLE_ENTRIES];
  logic [IW-1:0] rank_d [TABLE_ENTRIES];

  logic [IW-1:0] idx_q;
  logic          proc_v_q;
  logic [IW-1:0] proc_idx_q;

  logic          best_v_q;
  logic [IW-1:0] best_idx_q;
  logic [IW-1:0] best_rank_q;
  entry_t        best_word_q;
  logic          free_v_q;
  logic [IW-1:0] free_idx_q;

  logic          out_valid_q;
  logic [1:0]    verdict_q;
  logic [31:0]   nat_q;
  logic          full_q;

  logic          cur_v;
  logic [IW-1:0] cur_rank;
  logic          hit;
  logic          tick_on;
  logic          tick_free;
  logic          tick_wr;
  logic          pass;
  logic          trig_ok;
  logic          fwd_ok;
  logic [15:0]   reload;
  logic          c_wr;
  logic [IW-1:0] c_addr;
  entry_t        c_data;
  logic          c_ins;
  logic [1:0]    c_verdict;
  logic [31:0]   c_nat;
  logic          c_full;

  assign sts_o.rd_last  = idx_q == IW'(TABLE_ENTRIES - 1);
  assign sts_o.out_busy = out_valid_q && out_stall_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q   <= command_i;
      proto_q <= protocol_i;
      src_q   <= src_addr_i;
      dst_q   <= dst_addr_i;
      port_q  <= dst_port_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      proc_v_q <= 1'b0;
    end else begin
      proc_v_q <= cmd_i.rd_en;
      if (cmd_i.load)       idx_q <= '0;
      else if (cmd_i.rd_en) idx_q <= idx_q + 1'b1;
    end
  end

  // entry memory, one read and one write port
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_data_q  <= mem_q[idx_q];
      proc_idx_q <= idx_q;
    end
    if (wr_en) mem_q[wr_addr] <= wr_data;
  end

  assign cur_v    = valid_q[proc_idx_q];
  assign cur_rank = rank_q[proc_idx_q];
  assign tick_on  = proc_v_q && cmd_q == CMD_TICK && cur_v;
  assign tick_free = tick_on && rd_data_q.secs <= 16'd1;
  assign tick_wr  = tick_on && rd_data_q.secs > 16'd1;
  assign hit = cur_v && ((cmd_q == CMD_TRIGGER) ? rd_data_q.proto == proto_q
                                                : rd_data_q.lan != src_q);

  // newest match and lowest free index, tracked while the sweep goes by
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_v_q <= 1'b0;
      free_v_q <= 1'b0;
    end else if (cmd_i.load) begin
      best_v_q <= 1'b0;
      free_v_q <= 1'b0;
    end else if (proc_v_q) begin
      if (hit && (!best_v_q || cur_rank < best_rank_q)) best_v_q <= 1'b1;
      if (!cur_v) free_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_v_q) begin
      if (hit && (!best_v_q || cur_rank < best_rank_q)) begin
        best_idx_q  <= proc_idx_q;
        best_rank_q <= cur_rank;
        best_word_q <= rd_data_q;
      end
      if (!cur_v && !free_v_q) free_idx_q <= proc_idx_q;
    end
  end

  assign pass = (proto_q == PROTO_TCP || proto_q == PROTO_UDP) && src_q != dst_q &&
                src_q != 32'd0 && dst_q != 32'd0;
  assign trig_ok = (cfg_i.trig_proto == 8'd0 || cfg_i.trig_proto == proto_q) &&
                   port_in_list(cfg_i.trig_ports, cfg_i.trig_flags, port_q, PORT_SLOTS);
  assign fwd_ok  = (cfg_i.fwd_proto == 8'd0 || cfg_i.fwd_proto == proto_q) &&
                   port_in_list(cfg_i.fwd_ports, cfg_i.fwd_flags, port_q, PORT_SLOTS);
  assign reload  = (cfg_i.refresh != 16'd0) ? cfg_i.refresh : DEF_TIMEOUT;

  always_comb begin
    c_wr      = 1'b0;
    c_addr    = best_idx_q;
    c_data    = '{lan: src_q, proto: proto_q, secs: reload};
    c_ins     = 1'b0;
    c_verdict = VERDICT_CONTINUE;
    c_nat     = '0;
    c_full    = 1'b0;
    if (cmd_q != CMD_TICK && pass) begin
      if (cmd_q == CMD_TRIGGER) begin
        if (trig_ok) begin
          if (best_v_q) begin
            c_wr      = 1'b1;
            c_verdict = VERDICT_ACCEPT;
          end else if (free_v_q) begin
            c_wr      = 1'b1;
            c_ins     = 1'b1;
            c_addr    = free_idx_q;
            c_data.secs = DEF_TIMEOUT;
            c_verdict = VERDICT_ACCEPT;
          end else begin
            c_full = 1'b1;
          end
        end
      end else if (fwd_ok && best_v_q) begin
        if (cmd_q == CMD_LOOKUP) begin
          c_verdict = VERDICT_REDIRECT;
          c_nat     = best_word_q.lan;
        end else begin
          c_wr      = 1'b1;
          c_data    = '{lan: best_word_q.lan, proto: best_word_q.proto, secs: reload};
          c_verdict = VERDICT_ACCEPT;
        end
      end
    end
  end

  always_comb begin
    if (cmd_i.commit) begin
      wr_en   = c_wr;
      wr_addr = c_addr;
      wr_data = c_data;
    end else begin
      wr_en   = tick_wr;
      wr_addr = proc_idx_q;
      wr_data = '{lan: rd_data_q.lan, proto: rd_data_q.proto,
                  secs: rd_data_q.secs - 16'd1};
    end
  end

  // rank cells: freeing moves older entries down, insert pushes all live entries up
  always_comb begin
    valid_d = valid_q;
    rank_d  = rank_q;
    if (tick_free) begin
      valid_d[proc_idx_q] = 1'b0;
      for (int j = 0; j < TABLE_ENTRIES; j++) begin
        if (valid_q[j] && rank_q[j] > cur_rank) rank_d[j] = rank_q[j] - 1'b1;
      end
    end
    if (cmd_i.commit && c_ins) begin
      for (int j = 0; j < TABLE_ENTRIES; j++) begin
        if (valid_q[j]) rank_d[j] = rank_q[j] + 1'b1;
      end
      valid_d[free_idx_q] = 1'b1;
      rank_d[free_idx_q]  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= '0;
    else         valid_q <= valid_d;
  end

  always_ff @(posedge clk_i) begin
    rank_q <= rank_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      verdict_q <= c_verdict;
      nat_q     <= c_nat;
      full_q    <= c_full;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign verdict_o    = verdict_q;
  assign nat_addr_o   = nat_q;
  assign table_full_o = full_q;

  a_commit_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> !(out_valid_q && out_stall_i))
    else $error("result overwrote a waiting item");
  a_single_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.commit && proc_v_q))
    else $error("decision write collides with sweep write");
  a_insert_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && c_ins) |=> valid_q[$past(free_idx_q)])
    else $error("inserted entry not marked live");
  a_insert_needs_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && c_ins) |-> !valid_q[free_idx_q])
    else $error("insert into a live entry");

endmodule

// ===== rtl/port_trigger_table_unit.sv =====
// top level of the port trigger table
`timescale 1ns / 1ps
// Each item (event or tick) walks every table entry once through an entry memory
// with one read and one write port: an accept state, a sweep state reading the
// entries in turn, a drain state and a decision state, which waits while the
// result register is still held by out_stall_i. One item is in
// work at a time; a finished result waits in the output register while the next
// item is taken. Configuration is written over the apb port at byte address 8*i.
module port_trigger_table_unit import ptt_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES           = 16,
  parameter int unsigned PORT_SLOTS              = 4,
  parameter int unsigned DEFAULT_TIMEOUT_SECONDS = 600
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [7:0]  protocol_i,
  input  logic [31:0] src_addr_i,
  input  logic [31:0] dst_addr_i,
  input  logic [15:0] dst_port_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  verdict_o,
  output logic [31:0] nat_addr_o,
  output logic        table_full_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  cfg_t      cfg;
  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  ptt_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ptt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ptt_datapath #(
    .TABLE_ENTRIES           (TABLE_ENTRIES),
    .PORT_SLOTS              (PORT_SLOTS),
    .DEFAULT_TIMEOUT_SECONDS (DEFAULT_TIMEOUT_SECONDS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .command_i    (command_i),
    .protocol_i   (protocol_i),
    .src_addr_i   (src_addr_i),
    .dst_addr_i   (dst_addr_i),
    .dst_port_i   (dst_port_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .verdict_o    (verdict_o),
    .nat_addr_o   (nat_addr_o),
    .table_full_o (table_full_o)
  );

endmodule
